FILE: rtl/ctae_pkg.sv
// shared constants, types and the arctangent table of the azimuth/elevation converter
package ctae_pkg;

  localparam int CW = 32;                 // coordinate width
  localparam int AW = 16;                 // angle output width
  localparam int RW = 32;                 // range output width
  localparam int GUARD = 16;              // fraction bits added to coordinates
  localparam int XW = 52;                 // cordic x/y datapath width
  localparam int ZW = 35;                 // angle accumulator width, 2^31 = pi
  localparam int NW = CW + 1;             // width of a negated coordinate
  localparam int CORDIC_STAGES_DEF = 16;
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  // order of the three input coordinates
  typedef enum logic { FRAME_ENU = 1'b0, FRAME_SEZ = 1'b1 } frame_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/ctae_if.sv
// valid/ready channel interfaces for position input, result output and configuration
interface ctae_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [ctae_pkg::CW-1:0] coord_a;
  logic signed [ctae_pkg::CW-1:0] coord_b;
  logic signed [ctae_pkg::CW-1:0] coord_c;

  modport source (output valid, output coord_a, output coord_b, output coord_c,
                  input ready);
  modport sink   (input valid, input coord_a, input coord_b, input coord_c,
                  output ready);
endinterface

interface ctae_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [ctae_pkg::AW-1:0] azimuth;
  logic signed [ctae_pkg::AW-1:0] elevation;
  logic        [ctae_pkg::RW-1:0] slant_range;

  modport source (output valid, output azimuth, output elevation, output slant_range,
                  input ready);
  modport sink   (input valid, input azimuth, input elevation, input slant_range,
                  output ready);
endinterface

interface ctae_cfg_if;
  logic valid;
  logic ready;
  logic input_frame;

  modport source (output valid, output input_frame, input ready);
  modport sink   (input valid, input input_frame, output ready);
endinterface

FILE: rtl/ctae_cell.sv
// one cordic vectoring cell: a fixed shift and arctangent step, registered
module ctae_cell #(
  parameter int SHIFT = 0,
  parameter int SW    = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  ctae_pkg::vec_t       in_vec,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output ctae_pkg::vec_t       out_vec,
  output logic [SW-1:0]        out_side
);

  localparam logic [31:0] ATAN = ctae_pkg::atan_entry(SHIFT);
  localparam logic signed [ctae_pkg::ZW-1:0] ATAN_Z =
    $signed({{(ctae_pkg::ZW-32){1'b0}}, ATAN});

  logic                 valid_r;
  ctae_pkg::vec_t       vec_r;
  ctae_pkg::vec_t       vec_nxt;
  logic [SW-1:0]        side_r;
  logic signed [ctae_pkg::XW-1:0] dx;
  logic signed [ctae_pkg::XW-1:0] dy;

  always_comb begin
    dx = in_vec.y >>> SHIFT;
    dy = in_vec.x >>> SHIFT;
    if (!in_vec.y[ctae_pkg::XW-1]) begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + ATAN_Z;
    end else begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - ATAN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r  <= vec_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;
  assign out_side  = side_r;

endmodule

FILE: rtl/ctae_gain.sv
// two-stage cordic gain removal: split multiply by the inverse gain, then round and sum
module ctae_gain #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [ctae_pkg::XW-1:0] in_x,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output logic [ctae_pkg::XW-1:0]       out_mag,
  output logic [SW-1:0]                 out_side
);

  localparam int HW = ctae_pkg::XW - 33;   // high part of the non-negative magnitude

  logic [ctae_pkg::XW-2:0] u;
  logic                    va_r;
  logic                    vb_r;
  logic [HW+31:0]          p_hi_r;
  logic [63:0]             p_lo_r;
  logic [SW-1:0]           side_a_r;
  logic [SW-1:0]           side_b_r;
  logic [ctae_pkg::XW-1:0] mag_r;
  logic [64:0]             lo_rnd;
  logic [ctae_pkg::XW-1:0] mag_nxt;

  // a negative x reads as zero
  assign u = in_x[ctae_pkg::XW-1] ? '0 : in_x[ctae_pkg::XW-2:0];

  assign lo_rnd  = {1'b0, p_lo_r} + 65'h080000000;
  assign mag_nxt = {1'b0, p_hi_r} + {{(ctae_pkg::XW-33){1'b0}}, lo_rnd[64:32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi_r   <= u[ctae_pkg::XW-2:32] * ctae_pkg::INV_GAIN;
      p_lo_r   <= u[31:0] * ctae_pkg::INV_GAIN;
      side_a_r <= in_side;
      mag_r    <= mag_nxt;
      side_b_r <= side_a_r;
    end
  end

  assign out_valid = vb_r;
  assign out_mag   = mag_r;
  assign out_side  = side_b_r;

endmodule

FILE: rtl/cartesian_to_azimuth_elevation.sv
// top level: cartesian position vector to azimuth, elevation and slant range
//
// Converts one topocentric position vector per clock into azimuth (from north toward
// east, 32768 counts = pi), elevation (16384 counts = pi/2) and slant range (1/16 m,
// saturated at 2^32-1). Two chains of CORDIC_STAGES vectoring cells do the work: the
// first rotates (north, east) onto the north axis to give azimuth and horizontal
// magnitude, the second rotates (horizontal, up) to give elevation and range, each
// followed by a registered gain removal. A vector passes the input register, both
// chains and both gain removals, then the output register; one vector is taken every
// cycle as long as results drain. The whole pipeline advances together; a two-entry
// output register and skid stage let it run on while one result waits, and in_ready
// drops only once the skid stage holds a second waiting result. input_frame (0: east-
// north-up, 1: south-east-zenith, where north is the negated first coordinate) is
// written through cfg and must only change while no vector is in flight. A zero
// horizontal vector gives azimuth 0; a zero vector gives all-zero outputs.
module cartesian_to_azimuth_elevation #(
  parameter int CORDIC_STAGES = ctae_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ctae_in_if.sink        in_ch,
  ctae_out_if.source     out_ch,
  ctae_cfg_if.sink       cfg_ch
);

  localparam int CW = ctae_pkg::CW;
  localparam int XW = ctae_pkg::XW;
  localparam int ZW = ctae_pkg::ZW;
  localparam int AW = ctae_pkg::AW;
  localparam int RW = ctae_pkg::RW;
  localparam int NW = ctae_pkg::NW;
  localparam int GUARD = ctae_pkg::GUARD;
  localparam int S1W = CW + 2;          // pass 1 side data: up, horiz nonzero, any nonzero
  localparam int S2W = AW + 1;          // pass 2 side data: azimuth, any nonzero
  localparam int G2W = 2*AW + 1;        // final gain side data: azimuth, elevation, nonzero
  localparam int EW = ZW - 16;          // width of a rounded angle before truncation
  localparam logic signed [EW-1:0] EL_HI = EW'(16384);
  localparam logic signed [EW-1:0] EL_LO = -EW'(16384);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sh80000000);
  localparam logic signed [ZW-1:0] ANG_RND = ZW'(32768);

  // configuration register, always ready
  ctae_pkg::frame_t frame_r;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= ctae_pkg::FRAME_ENU;
    end else if (cfg_ch.valid) begin
      frame_r <= ctae_pkg::frame_t'(cfg_ch.input_frame);
    end
  end

  // pipeline enable: the whole chain stalls only when the skid stage is occupied
  logic en;
  logic skid_valid_r;
  assign en = !skid_valid_r;
  assign in_ch.ready = en;

  // input stage: frame mapping, fold into the right half plane
  logic signed [NW-1:0] north;
  logic signed [NW-1:0] east;
  logic signed [NW-1:0] n_fold;
  logic signed [NW-1:0] e_fold;
  ctae_pkg::vec_t       v0_nxt;
  logic                 nz_h;
  logic                 nz_all;

  always_comb begin
    if (frame_r == ctae_pkg::FRAME_SEZ) begin
      north = -NW'(in_ch.coord_a);
      east  = NW'(in_ch.coord_b);
    end else begin
      north = NW'(in_ch.coord_b);
      east  = NW'(in_ch.coord_a);
    end
    n_fold   = north[NW-1] ? -north : north;
    e_fold   = north[NW-1] ? -east : east;
    v0_nxt.x = XW'({n_fold, {GUARD{1'b0}}});
    v0_nxt.y = {{(XW-NW-GUARD){e_fold[NW-1]}}, e_fold, {GUARD{1'b0}}};
    if (!north[NW-1]) begin
      v0_nxt.z = '0;
    end else if (!east[NW-1]) begin
      v0_nxt.z = HALF_TURN;
    end else begin
      v0_nxt.z = -HALF_TURN;
    end
    nz_h   = (north != '0) || (east != '0);
    nz_all = nz_h || (in_ch.coord_c != '0);
  end

  logic           v0_valid_r;
  ctae_pkg::vec_t v0_r;
  logic [S1W-1:0] s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_valid_r <= 1'b0;
    end else if (en) begin
      v0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r <= v0_nxt;
      s0_r <= {in_ch.coord_c, nz_h, nz_all};
    end
  end

  // pass 1: (north, east) -> azimuth, horizontal magnitude
  logic           p1_valid [0:CORDIC_STAGES];
  ctae_pkg::vec_t p1_vec   [0:CORDIC_STAGES];
  logic [S1W-1:0] p1_side  [0:CORDIC_STAGES];

  assign p1_valid[0] = v0_valid_r;
  assign p1_vec[0]   = v0_r;
  assign p1_side[0]  = s0_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pass1
    ctae_cell #(.SHIFT(i), .SW(S1W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (p1_valid[i]),
      .in_vec    (p1_vec[i]),
      .in_side   (p1_side[i]),
      .out_valid (p1_valid[i+1]),
      .out_vec   (p1_vec[i+1]),
      .out_side  (p1_side[i+1])
    );
  end

  // azimuth rounding; an angle of +pi wraps to -32768 by truncation
  logic [ZW-1:0]  az_rnd;
  logic [AW-1:0]  az_val;
  logic [S1W+AW-1:0] g1_side_in;

  assign az_rnd = p1_vec[CORDIC_STAGES].z + ANG_RND;
  assign az_val = p1_side[CORDIC_STAGES][1] ? az_rnd[AW+15:16] : '0;
  assign g1_side_in = {p1_side[CORDIC_STAGES], az_val};

  logic              g1_valid;
  logic [XW-1:0]     g1_mag;
  logic [S1W+AW-1:0] g1_side;

  ctae_gain #(.SW(S1W+AW)) u_gain_h (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p1_valid[CORDIC_STAGES]),
    .in_x      (p1_vec[CORDIC_STAGES].x),
    .in_side   (g1_side_in),
    .out_valid (g1_valid),
    .out_mag   (g1_mag),
    .out_side  (g1_side)
  );

  // pass 2 input: (horizontal, up); horizontal is forced to zero for a zero vector pair
  logic signed [CW-1:0] up_c;
  ctae_pkg::vec_t       v2_in;

  assign up_c     = g1_side[S1W+AW-1:AW+2];
  assign v2_in.x  = g1_side[AW+1] ? $signed(g1_mag) : '0;
  assign v2_in.y  = {{(XW-CW-GUARD){up_c[CW-1]}}, up_c, {GUARD{1'b0}}};
  assign v2_in.z  = '0;

  logic           p2_valid [0:CORDIC_STAGES];
  ctae_pkg::vec_t p2_vec   [0:CORDIC_STAGES];
  logic [S2W-1:0] p2_side  [0:CORDIC_STAGES];

  assign p2_valid[0] = g1_valid;
  assign p2_vec[0]   = v2_in;
  assign p2_side[0]  = {g1_side[AW-1:0], g1_side[AW]};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pass2
    ctae_cell #(.SHIFT(i), .SW(S2W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (p2_valid[i]),
      .in_vec    (p2_vec[i]),
      .in_side   (p2_side[i]),
      .out_valid (p2_valid[i+1]),
      .out_vec   (p2_vec[i+1]),
      .out_side  (p2_side[i+1])
    );
  end

  // elevation rounding and clamp to a quarter turn either way
  logic [ZW-1:0]          el_rnd;
  logic signed [EW-1:0]   el_full;
  logic [AW-1:0]          el_val;
  logic [G2W-1:0]         g2_side_in;

  always_comb begin
    el_rnd  = p2_vec[CORDIC_STAGES].z + ANG_RND;
    el_full = $signed(el_rnd[ZW-1:16]);
    if (!p2_side[CORDIC_STAGES][0]) begin
      el_val = '0;
    end else if (el_full > EL_HI) begin
      el_val = AW'(EL_HI);
    end else if (el_full < EL_LO) begin
      el_val = AW'(EL_LO);
    end else begin
      el_val = el_full[AW-1:0];
    end
  end

  assign g2_side_in = {p2_side[CORDIC_STAGES][S2W-1:1], el_val, p2_side[CORDIC_STAGES][0]};

  logic           g2_valid;
  logic [XW-1:0]  g2_mag;
  logic [G2W-1:0] g2_side;

  ctae_gain #(.SW(G2W)) u_gain_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p2_valid[CORDIC_STAGES]),
    .in_x      (p2_vec[CORDIC_STAGES].x),
    .in_side   (g2_side_in),
    .out_valid (g2_valid),
    .out_mag   (g2_mag),
    .out_side  (g2_side)
  );

  // range: drop guard bits with rounding, saturate to 32 bits
  logic [XW:0]          rng_rnd;
  logic [XW-GUARD:0]    rng_full;
  logic [RW-1:0]        rng_val;

  always_comb begin
    rng_rnd  = {1'b0, g2_mag} + (XW+1)'(1 << (GUARD-1));
    rng_full = rng_rnd[XW:GUARD];
    if (!g2_side[0]) begin
      rng_val = '0;
    end else if (rng_full[XW-GUARD:RW] != '0) begin
      rng_val = '1;
    end else begin
      rng_val = rng_full[RW-1:0];
    end
  end

  // output register plus skid stage
  logic          out_valid_r;
  logic [AW-1:0] out_az_r;
  logic [AW-1:0] out_el_r;
  logic [RW-1:0] out_rng_r;
  logic [AW-1:0] skid_az_r;
  logic [AW-1:0] skid_el_r;
  logic [RW-1:0] skid_rng_r;
  logic          push;
  logic          out_free;

  assign push     = en && g2_valid;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_az_r  <= skid_az_r;
        out_el_r  <= skid_el_r;
        out_rng_r <= skid_rng_r;
      end else begin
        out_az_r  <= g2_side[G2W-1:AW+1];
        out_el_r  <= g2_side[AW:1];
        out_rng_r <= rng_val;
      end
    end else if (push) begin
      skid_az_r  <= g2_side[G2W-1:AW+1];
      skid_el_r  <= g2_side[AW:1];
      skid_rng_r <= rng_val;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.azimuth     = out_az_r;
  assign out_ch.elevation   = out_el_r;
  assign out_ch.slant_range = out_rng_r;

`ifndef SYNTHESIS
  // a waiting skid entry always sits behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  // a result arriving at a blocked output must land in the skid stage
  a_blocked_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("result dropped at blocked output");

  // clamped elevation stays within a quarter turn
  a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_el_r) <= 16'sd16384 && $signed(out_el_r) >= -16'sd16384))
    else $error("elevation out of range");

  // input stalls exactly while a second result waits
  a_stall_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && push && !skid_valid_r) |=> !in_ch.ready)
    else $error("input accepted with skid stage full");
`endif

endmodule
